/* hdl/assert_macros.svh */
// assertion macros used by the top level rtl file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_IMPLIES(label, clk, rstn, pre, post) \
    label: assert property (@(posedge clk) disable iff (!rstn) (pre) |-> (post)) \
        else $error("assertion failed");
`define ASSERT_NEXT(label, clk, rstn, pre, post) \
    label: assert property (@(posedge clk) disable iff (!rstn) (pre) |=> (post)) \
        else $error("assertion failed");
`else
`define ASSERT_IMPLIES(label, clk, rstn, pre, post)
`define ASSERT_NEXT(label, clk, rstn, pre, post)
`endif
`endif

/* hdl/sobel_pkg.sv */
// shared types, constants and helpers for the sobel edge block
`default_nettype none
package sobel_pkg;
    localparam int DEF_MAX_WIDTH  = 1024;
    localparam int DEF_MAX_HEIGHT = 4096;
    localparam logic [10:0] RST_WIDTH  = 11'd640;
    localparam logic [12:0] RST_HEIGHT = 13'd480;
    localparam logic [0:0] REG_WIDTH  = 1'b0;
    localparam logic [0:0] REG_HEIGHT = 1'b1;
    localparam logic CMD_PIXEL = 1'b0;

    // controller to datapath
    typedef struct packed {
        logic advance;   // shift one position, write line stores
        logic use_zero;  // shift a zero pixel
        logic compute;   // start the root units on the squared gradients
        logic restart;   // clear window
    } sobel_cmd_t;

    // gradient of one channel, |g| <= 1020
    function automatic logic signed [11:0] grad_x(input logic [7:0] p [0:8], input logic [8:0] m);
        logic signed [11:0] s;
        s = 12'sd0;
        if (m[2]) s = s + $signed({4'd0, p[2]});
        if (m[0]) s = s - $signed({4'd0, p[0]});
        if (m[5]) s = s + $signed({3'd0, p[5], 1'b0});
        if (m[3]) s = s - $signed({3'd0, p[3], 1'b0});
        if (m[8]) s = s + $signed({4'd0, p[8]});
        if (m[6]) s = s - $signed({4'd0, p[6]});
        return s;
    endfunction

    function automatic logic signed [11:0] grad_y(input logic [7:0] p [0:8], input logic [8:0] m);
        logic signed [11:0] s;
        s = 12'sd0;
        if (m[6]) s = s + $signed({4'd0, p[6]});
        if (m[0]) s = s - $signed({4'd0, p[0]});
        if (m[7]) s = s + $signed({3'd0, p[7], 1'b0});
        if (m[1]) s = s - $signed({3'd0, p[1], 1'b0});
        if (m[8]) s = s + $signed({4'd0, p[8]});
        if (m[2]) s = s - $signed({4'd0, p[2]});
        return s;
    endfunction
endpackage
`default_nettype wire

/* hdl/sobel_ram.sv */
// generic single port ram with registered read
`default_nettype none
module sobel_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 1024
) (
    input  wire logic                     aclk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] addr,
    input  wire logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]              rdata
);
    logic [WIDTH-1:0] mem [0:DEPTH-1];
    always_ff @(posedge aclk) begin
        if (we) mem[addr] <= wdata;
        rdata <= mem[addr];
    end
endmodule
`default_nettype wire

/* hdl/sobel_sqrt.sv */
// bit-serial rounded square root, one result bit per cycle
`default_nettype none
module sobel_sqrt (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        start,
    input  wire logic [20:0] radicand,
    output logic             busy,
    output logic [7:0]       root
);
    logic [20:0] s_reg, s_next;
    logic [7:0]  r_reg, r_next, bit_reg, bit_next;
    logic        busy_reg, busy_next, sat_reg, sat_next;
    logic [7:0]  t;
    logic [15:0] tt, rr;
    logic [8:0]  fin;

    always_comb begin
        s_next = s_reg; r_next = r_reg; bit_next = bit_reg;
        busy_next = busy_reg; sat_next = sat_reg;
        t  = r_reg | bit_reg;
        tt = t * t;
        rr = r_reg * r_reg;
        if (start) begin
            s_next = radicand; r_next = 8'd0; bit_next = 8'h80;
            busy_next = 1'b1; sat_next = radicand > 21'd65280;
        end else if (busy_reg) begin
            if ({5'd0, tt} <= s_reg) r_next = t;
            bit_next = bit_reg >> 1;
            if (bit_reg == 8'd1) busy_next = 1'b0;
        end
        fin = {1'b0, r_reg} + {8'd0, ((s_reg - {5'd0, rr}) > {13'd0, r_reg})};
    end

    assign busy = busy_reg;
    assign root = (sat_reg || fin[8]) ? 8'hFF : fin[7:0];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
        end
        s_reg <= s_next; r_reg <= r_next; bit_reg <= bit_next; sat_reg <= sat_next;
    end
endmodule
`default_nettype wire

/* hdl/sobel_datapath.sv */
// line stores, window, gradients and magnitude units
`default_nettype none
module sobel_datapath #(
    parameter int MAX_WIDTH = sobel_pkg::DEF_MAX_WIDTH
) (
    input  wire logic                         aclk,
    input  wire logic                         aresetn,
    input  wire sobel_pkg::sobel_cmd_t        cmd,
    input  wire logic [$clog2(MAX_WIDTH)-1:0] col,
    input  wire logic [23:0]                  pix,
    input  wire logic [8:0]                   mask,
    output logic                              busy,
    output logic [23:0]                       edges
);
    import sobel_pkg::*;
    localparam int AW = $clog2(MAX_WIDTH);

    logic [23:0] a_rd, b_rd, wpix;
    logic [23:0] win_reg [0:8];
    logic [7:0]  p [0:2][0:8];
    logic [20:0] sq [0:2];
    logic [2:0]  bz;
    logic signed [11:0] gx [0:2];
    logic signed [11:0] gy [0:2];
    logic [10:0] ax [0:2];
    logic [10:0] ay [0:2];
    logic [2:0]  go_reg;
    logic [AW-1:0] addr;

    assign wpix = cmd.use_zero ? 24'd0 : pix;
    assign addr = col;

    // row above feeds row two above; reads are registered
    sobel_ram #(.WIDTH(24), .DEPTH(MAX_WIDTH)) u_above (
        .aclk(aclk), .we(cmd.advance), .addr(addr), .wdata(wpix), .rdata(a_rd));
    sobel_ram #(.WIDTH(24), .DEPTH(MAX_WIDTH)) u_two (
        .aclk(aclk), .we(cmd.advance), .addr(addr), .wdata(a_rd), .rdata(b_rd));

    // window index m*3+n; column 2 holds fresh data
    always_ff @(posedge aclk) begin
        if (!aresetn || cmd.restart) begin
            for (int i = 0; i < 9; i++) win_reg[i] <= 24'd0;
        end else if (cmd.advance) begin
            for (int m = 0; m < 3; m++) begin
                win_reg[m*3]   <= win_reg[m*3+1];
                win_reg[m*3+1] <= win_reg[m*3+2];
            end
            win_reg[2] <= b_rd;
            win_reg[5] <= a_rd;
            win_reg[8] <= wpix;
        end
    end

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            for (int i = 0; i < 9; i++) p[k][i] = win_reg[i][16-8*k +: 8];
            gx[k] = grad_x(p[k], mask);
            gy[k] = grad_y(p[k], mask);
            ax[k] = gx[k][11] ? 11'(-gx[k]) : gx[k][10:0];
            ay[k] = gy[k][11] ? 11'(-gy[k]) : gy[k][10:0];
        end
    end

    // squares registered before the root unit
    always_ff @(posedge aclk) begin
        if (!aresetn) go_reg <= 3'd0;
        else go_reg <= {3{cmd.compute}};
        for (int k = 0; k < 3; k++)
            sq[k] <= ({10'd0, ax[k]} * {10'd0, ax[k]}) + ({10'd0, ay[k]} * {10'd0, ay[k]});
    end

    for (genvar k = 0; k < 3; k++) begin : g_root
        sobel_sqrt u_sqrt (.aclk(aclk), .aresetn(aresetn), .start(go_reg[k]),
            .radicand(sq[k]), .busy(bz[k]), .root(edges[16-8*k +: 8]));
    end
    assign busy = |bz || go_reg[0];
endmodule
`default_nettype wire

/* hdl/sobel_ctrl.sv */
// sequencer: frame counters, drain handling and handshakes
`default_nettype none
module sobel_ctrl #(
    parameter int MAX_WIDTH  = sobel_pkg::DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = sobel_pkg::DEF_MAX_HEIGHT
) (
    input  wire logic                         aclk,
    input  wire logic                         aresetn,
    input  wire logic                         cfg_wr,
    input  wire logic [10:0]                  width_in,
    input  wire logic [12:0]                  height_in,
    input  wire logic                         in_valid,
    input  wire logic                         in_cmd,
    output logic                              in_ready,
    output logic                              out_valid,
    input  wire logic                         out_ready,
    output logic                              out_last,
    input  wire logic                         dp_busy,
    output sobel_pkg::sobel_cmd_t             cmd,
    output logic [$clog2(MAX_WIDTH)-1:0]      col,
    output logic [8:0]                        mask
);
    import sobel_pkg::*;
    localparam int CW = $clog2(MAX_WIDTH) + 1;
    localparam int RW = $clog2(MAX_HEIGHT) + 1;
    localparam logic [2:0] ST_IDLE = 3'd0, ST_READ = 3'd1, ST_SHIFT = 3'd2,
                           ST_CALC = 3'd3, ST_ROOT = 3'd4, ST_OUT = 3'd5;

    logic [2:0]    state_reg, state_next;
    logic [CW-1:0] icol_reg, icol_next, ocol_reg, ocol_next, w;
    logic [RW-1:0] irow_reg, irow_next, orow_reg, orow_next, h;
    logic          drain_reg, drain_next, again_reg, again_next, last_reg, last_next;
    logic          rdy, last_now;

    always_comb begin
        w = (width_in == 11'd0) ? CW'(1) :
            ({21'd0, width_in} > 32'(MAX_WIDTH)) ? CW'(MAX_WIDTH) : CW'(width_in);
        h = (height_in == 13'd0) ? RW'(1) :
            ({19'd0, height_in} > 32'(MAX_HEIGHT)) ? RW'(MAX_HEIGHT) : RW'(height_in);
    end

    assign col = icol_reg[CW-2:0];
    assign in_ready = (state_reg == ST_IDLE) && !cfg_wr;
    assign out_valid = (state_reg == ST_OUT);
    assign out_last = last_reg;
    assign rdy = (irow_reg >= RW'(2)) || (irow_reg == RW'(1) && icol_reg >= CW'(1));
    assign last_now = (orow_reg == h - RW'(1)) && (ocol_reg == w - CW'(1));

    // border mask of the output position, index m*3+n
    always_comb begin
        for (int m = 0; m < 3; m++)
            for (int n = 0; n < 3; n++)
                mask[m*3+n] = !((m == 0 && orow_reg == RW'(0)) ||
                                (m == 2 && orow_reg + RW'(1) >= h) ||
                                (n == 0 && ocol_reg == CW'(0)) ||
                                (n == 2 && ocol_reg + CW'(1) >= w));
    end

    always_comb begin
        state_next = state_reg; icol_next = icol_reg; irow_next = irow_reg;
        ocol_next = ocol_reg; orow_next = orow_reg; drain_next = drain_reg;
        again_next = again_reg; last_next = last_reg;
        cmd = '0;
        unique case (state_reg)
            ST_IDLE: begin
                if (in_valid && !cfg_wr) begin
                    drain_next = irow_reg >= h;
                    again_next = irow_reg >= h;
                    if (irow_reg < h && in_cmd != CMD_PIXEL) state_next = ST_IDLE;
                    else state_next = ST_READ;
                end
            end
            ST_READ: state_next = ST_SHIFT;   // line store read latency
            ST_SHIFT: begin
                cmd.advance = 1'b1;
                cmd.use_zero = drain_reg;
                icol_next = icol_reg + CW'(1);
                if (icol_next >= w) begin
                    icol_next = '0;
                    irow_next = irow_reg + RW'(1);
                end
                if (rdy) state_next = ST_CALC;
                else if (again_reg) begin
                    again_next = 1'b0;
                    state_next = ST_READ;
                end else state_next = ST_IDLE;
            end
            ST_CALC: begin
                cmd.compute = 1'b1;
                last_next = last_now;
                state_next = ST_ROOT;
            end
            ST_ROOT: if (!dp_busy) state_next = ST_OUT;
            ST_OUT: begin
                if (out_ready) begin
                    state_next = ST_IDLE;
                    if (last_reg) begin
                        cmd.restart = 1'b1;
                        icol_next = '0; irow_next = '0; ocol_next = '0; orow_next = '0;
                    end else begin
                        ocol_next = ocol_reg + CW'(1);
                        if (ocol_next >= w) begin
                            ocol_next = '0;
                            orow_next = orow_reg + RW'(1);
                        end
                    end
                end
            end
            default: state_next = ST_IDLE;
        endcase
        if (cfg_wr) begin
            cmd.restart = 1'b1; state_next = ST_IDLE;
            icol_next = '0; irow_next = '0; ocol_next = '0; orow_next = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            icol_reg <= '0; irow_reg <= '0; ocol_reg <= '0; orow_reg <= '0;
            drain_reg <= 1'b0; again_reg <= 1'b0; last_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            icol_reg <= icol_next; irow_reg <= irow_next;
            ocol_reg <= ocol_next; orow_reg <= orow_next;
            drain_reg <= drain_next; again_reg <= again_next; last_reg <= last_next;
        end
    end
endmodule
`default_nettype wire

/* hdl/sobel_edge_magnitude_rgb.sv */
// top level of the rgb sobel edge magnitude block
`default_nettype none
`include "assert_macros.svh"
// Sobel 3x3 edge magnitude on an rgb raster stream, one transaction at a time. A
// transaction that yields a result passes through the accepting cycle, one line store
// read, one window shift, one gradient and squaring stage, the root start, the
// bit-serial square root, a check that the root units are idle, and the offer of the
// result, which lasts until m_tready is high. A drain after the frame that needs two
// window shifts goes through the read and shift steps twice. A transaction without
// a result ends after the read and the shift, and a drain sent before the frame is
// complete is accepted and ignored. A result for a pixel comes out W+1 pixels
// later; after the frame's last pixel, each further transaction drains one result.
// Pixels outside the frame count as zero. Writing either register restarts the frame
// and drops pending results.
module sobel_edge_magnitude_rgb #(
    parameter int MAX_WIDTH  = sobel_pkg::DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = sobel_pkg::DEF_MAX_HEIGHT
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [23:0] s_tdata,   // red_in, green_in, blue_in
    input  wire logic        s_tuser,   // cmd
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [23:0]      m_tdata,   // red_edge, green_edge, blue_edge
    output logic             m_tlast,   // last_in_frame
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);
    import sobel_pkg::*;

    logic [10:0] width_reg;
    logic [12:0] height_reg;
    logic        wr, wr_width, wr_height;
    sobel_cmd_t  cmd;
    logic [$clog2(MAX_WIDTH)-1:0] col;
    logic [8:0]  mask;
    logic        busy;
    logic [23:0] edges;

    assign pready = 1'b1;
    assign wr = psel && penable && pwrite;
    // registers sit on word addresses, selected by paddr[2]
    assign wr_width  = wr && (paddr[1:0] == 2'd0) && (paddr[2] == REG_WIDTH);
    assign wr_height = wr && (paddr[1:0] == 2'd0) && (paddr[2] == REG_HEIGHT);
    assign prdata = (paddr[2] == REG_HEIGHT) ? {19'd0, height_reg} : {21'd0, width_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            width_reg <= RST_WIDTH; height_reg <= RST_HEIGHT;
        end else begin
            if (wr_width) width_reg <= pwdata[10:0];
            if (wr_height) height_reg <= pwdata[12:0];
        end
    end

    sobel_ctrl #(.MAX_WIDTH(MAX_WIDTH), .MAX_HEIGHT(MAX_HEIGHT)) u_ctrl (
        .aclk(aclk), .aresetn(aresetn),
        .cfg_wr(wr_width || wr_height),
        .width_in(width_reg), .height_in(height_reg),
        .in_valid(s_tvalid), .in_cmd(s_tuser), .in_ready(s_tready),
        .out_valid(m_tvalid), .out_ready(m_tready), .out_last(m_tlast),
        .dp_busy(busy), .cmd(cmd), .col(col), .mask(mask));

    // input pixel held from acceptance until the shift
    logic [23:0] pix_reg;
    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) pix_reg <= {s_tdata[7:0], s_tdata[15:8], s_tdata[23:16]};
    end

    sobel_datapath #(.MAX_WIDTH(MAX_WIDTH)) u_dp (
        .aclk(aclk), .aresetn(aresetn), .cmd(cmd), .col(col), .pix(pix_reg),
        .mask(mask), .busy(busy), .edges(edges));

    assign m_tdata = {edges[7:0], edges[15:8], edges[23:16]};

    // never accept input while a result is offered
    `ASSERT_IMPLIES(a_no_overlap, aclk, aresetn, m_tvalid, !s_tready)
    // a result is offered only after the root units finished
    `ASSERT_IMPLIES(a_root_done, aclk, aresetn, m_tvalid, !busy)
    // a taken last result restarts the frame
    `ASSERT_NEXT(a_restart, aclk, aresetn, m_tvalid && m_tready && m_tlast, s_tready)
endmodule
`default_nettype wire
